FILE: hdl/awsd_pkg.sv
// Shared types and constants for the ADC window switch debounce block.
package awsd_pkg;

    localparam int SAMPLE_W  = 12;
    localparam int PART_W    = SAMPLE_W + 1;
    localparam int SUM_W     = 15;
    localparam int NUM_IN    = 8;
    localparam int NUM_LANES = NUM_IN / 2;
    localparam int CFG_IDX_W = 3;

    // Switch class codes
    typedef enum logic [1:0] {
        CLASS_INDET = 2'd0,
        CLASS_CLOSE = 2'd1,
        CLASS_OPEN  = 2'd2,
        CLASS_NONE  = 2'd3
    } class_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSE_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_LOW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OPEN_HIGH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LOW   = 3'd4;

    // Threshold reset values in raw-sum units
    localparam logic [SUM_W-1:0] CLOSE_LOW_RST  = 15'd6365;
    localparam logic [SUM_W-1:0] CLOSE_HIGH_RST = 15'd10821;
    localparam logic [SUM_W-1:0] OPEN_LOW_RST   = 15'd11457;
    localparam logic [SUM_W-1:0] OPEN_HIGH_RST  = 15'd15913;
    localparam logic [SUM_W-1:0] NONE_LOW_RST   = 15'd28007;

    // Window thresholds handed to the merge stage
    typedef struct packed {
        logic [SUM_W-1:0] close_low;
        logic [SUM_W-1:0] close_high;
        logic [SUM_W-1:0] open_low;
        logic [SUM_W-1:0] open_high;
        logic [SUM_W-1:0] none_low;
    } thresh_t;

endpackage

FILE: hdl/awsd_lane.sv
// One summing lane: adds a pair of samples, dropping samples past the reading length.
module awsd_lane
    import awsd_pkg::*;
#(
    parameter int LANE    = 0,
    parameter int SAMPLES = 8
)
(
    input  logic [SAMPLE_W-1:0] sample_a,
    input  logic [SAMPLE_W-1:0] sample_b,
    output logic [PART_W-1:0]   part_sum
);

    localparam bit USE_A = (2 * LANE) < SAMPLES;
    localparam bit USE_B = (2 * LANE + 1) < SAMPLES;

    logic [SAMPLE_W-1:0] a_masked;
    logic [SAMPLE_W-1:0] b_masked;

    // Mask unused samples
    assign a_masked = USE_A ? sample_a : '0;
    assign b_masked = USE_B ? sample_b : '0;

    assign part_sum = {1'b0, a_masked} + {1'b0, b_masked};

endmodule

FILE: hdl/awsd_merge.sv
// Merge stage: adds lane partial sums and sorts the reading into a window class.
module awsd_merge
    import awsd_pkg::*;
(
    input  logic [PART_W-1:0] part_sum [NUM_LANES],
    input  thresh_t           thr,
    output class_t            cls
);

    logic [SUM_W-1:0] sum;
    logic             in_close;
    logic             in_open;
    logic             in_none;

    // Sum of the lane results (max 32760, fits 15 bits)
    always_comb
    begin
        sum = '0;
        for (int i = 0; i < NUM_LANES; i++)
        begin
            sum = sum + SUM_W'(part_sum[i]);
        end
    end

    // Window compares run side by side
    assign in_close = (sum > thr.close_low) && (sum < thr.close_high);
    assign in_open  = (sum > thr.open_low) && (sum < thr.open_high);
    assign in_none  = (sum > thr.none_low);

    // Priority: close, then open, then none
    always_comb
    begin
        if (in_close)
            cls = CLASS_CLOSE;
        else if (in_open)
            cls = CLASS_OPEN;
        else if (in_none)
            cls = CLASS_NONE;
        else
            cls = CLASS_INDET;
    end

endmodule

FILE: hdl/adc_window_switch_debounce.sv
// Top level of the ADC window switch sense with two-reading debounce.
// Takes one reading of eight 12-bit samples per clock, sustained unless stalled,
// and returns one result per reading: the first stage sums sample pairs in four
// lanes, the second merges the lane sums, runs the window compares and updates
// the debounce state, whose result sits in an output register. The debounce state
// feedback lives entirely in the second stage. Thresholds must be written through
// the cfg port while no reading is in flight; the block leaves this to the user.
module adc_window_switch_debounce
    import awsd_pkg::*;
#(
    parameter int SAMPLES_PER_READING = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  sample_0,
    input  logic [SAMPLE_W-1:0]  sample_1,
    input  logic [SAMPLE_W-1:0]  sample_2,
    input  logic [SAMPLE_W-1:0]  sample_3,
    input  logic [SAMPLE_W-1:0]  sample_4,
    input  logic [SAMPLE_W-1:0]  sample_5,
    input  logic [SAMPLE_W-1:0]  sample_6,
    input  logic [SAMPLE_W-1:0]  sample_7,

    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           reading_class,
    output logic [1:0]           debounced_state,
    output logic                 committed,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SUM_W-1:0]     cfg_data
);

    logic [SAMPLE_W-1:0] samples [NUM_IN];
    logic [PART_W-1:0]   part_comb [NUM_LANES];
    logic [PART_W-1:0]   part_reg  [NUM_LANES];
    logic                s1_valid_reg;
    logic                s1_move;
    logic                in_take;

    thresh_t             thr_reg;
    class_t              cls;
    logic                commit;
    class_t              pending_reg;
    class_t              pending_next;
    class_t              stable_reg;
    class_t              stable_next;

    logic                out_valid_reg;
    class_t              out_class_reg;
    class_t              out_state_reg;
    logic                out_commit_reg;

    assign samples[0] = sample_0;
    assign samples[1] = sample_1;
    assign samples[2] = sample_2;
    assign samples[3] = sample_3;
    assign samples[4] = sample_4;
    assign samples[5] = sample_5;
    assign samples[6] = sample_6;
    assign samples[7] = sample_7;

    // Handshake: stage 1 drains into the output register when that is free or taken
    assign s1_move  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_take  = in_valid && !in_stall;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg.close_low  <= CLOSE_LOW_RST;
            thr_reg.close_high <= CLOSE_HIGH_RST;
            thr_reg.open_low   <= OPEN_LOW_RST;
            thr_reg.open_high  <= OPEN_HIGH_RST;
            thr_reg.none_low   <= NONE_LOW_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CLOSE_LOW:  thr_reg.close_low  <= cfg_data;
                REG_CLOSE_HIGH: thr_reg.close_high <= cfg_data;
                REG_OPEN_LOW:   thr_reg.open_low   <= cfg_data;
                REG_OPEN_HIGH:  thr_reg.open_high  <= cfg_data;
                REG_NONE_LOW:   thr_reg.none_low   <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Summing lanes
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        awsd_lane #(
            .LANE    (g),
            .SAMPLES (SAMPLES_PER_READING)
        ) u_lane (
            .sample_a (samples[2*g]),
            .sample_b (samples[2*g+1]),
            .part_sum (part_comb[g])
        );
    end

    // Stage 1 valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!in_stall)
            s1_valid_reg <= in_valid;
    end

    // Stage 1 payload
    always_ff @(posedge clk)
    begin
        if (in_take)
            part_reg <= part_comb;
    end

    // Merge and classify
    awsd_merge u_merge (
        .part_sum (part_reg),
        .thr      (thr_reg),
        .cls      (cls)
    );

    // Debounce update
    assign commit = (cls == CLASS_INDET) || (cls == pending_reg);

    always_comb
    begin
        pending_next = pending_reg;
        stable_next  = stable_reg;
        if (s1_valid_reg && s1_move)
        begin
            if (commit)
            begin
                stable_next  = cls;
                pending_next = CLASS_INDET;
            end
            else
            begin
                pending_next = cls;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= CLASS_INDET;
            stable_reg  <= CLASS_INDET;
        end
        else
        begin
            pending_reg <= pending_next;
            stable_reg  <= stable_next;
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= s1_valid_reg;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && s1_move)
        begin
            out_class_reg  <= cls;
            out_state_reg  <= stable_next;
            out_commit_reg <= commit;
        end
    end

    assign out_valid       = out_valid_reg;
    assign reading_class   = out_class_reg;
    assign debounced_state = out_state_reg;
    assign committed       = out_commit_reg;

endmodule
